// ===== src/cle_pkg.sv =====
// Shared types and constants for the console line editor.
// Request and result payloads, command records and the terminal byte codes.
// No dependencies.
package cle_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       line_write;
    logic [7:0] line_index;
    logic [6:0] line_char;
    logic       line_done;
    logic [7:0] line_length;
    logic       aborted;
    logic       last;
  } res_t;

  typedef enum logic [3:0] {
    OP_ABORT = 4'b0001,
    OP_EOL   = 4'b0010,
    OP_ERASE = 4'b0100,
    OP_PUT   = 4'b1000
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] len;
    logic [6:0] chr;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = 2;
  localparam int LEN_REACH = 256;

  localparam logic [8:0] CAP_RESET = 9'h100;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_DEL   = 8'h7f;

endpackage

// ===== src/console_line_editor_core.sv =====
// Console line editor top level: capacity register, front end, command queue
// and back end. Depends on cle_pkg, cle_front, cle_cmd_fifo and cle_back.
// A request's first result passes through the command queue and then the output register.
// Throughput: one request per cycle while the four-entry command queue has room; the back
// end gives one result per cycle while results are popped; 0 to 3 per request (erase 3, line end 2).
// Reset: clears line length and queue, empties the output register; capacity returns to 256.
module console_line_editor_core #(
  parameter int LINE_MAX = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  cle_pkg::req_t request,
  input  logic          cfg_we,
  input  logic [8:0]    cfg_data,
  output logic          empty,
  input  logic          pop,
  output cle_pkg::res_t result
);
  import cle_pkg::*;

  localparam int         LimitCap = (LINE_MAX < LEN_REACH) ? LINE_MAX : LEN_REACH;
  localparam logic [8:0] CapLimit = 9'(LimitCap);

  logic [8:0] line_capacity;
  logic [8:0] eff_cap;
  logic       cmd_push;
  logic       cmd_pop;
  cmd_t       cmd_in;
  cmd_t       cmd_out;
  q_stat_t    q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_capacity <= CAP_RESET;
    end else if (cfg_we) begin
      line_capacity <= cfg_data;
    end
  end

  always_comb begin
    eff_cap = (line_capacity > CapLimit) ? CapLimit : line_capacity;
    if (eff_cap == 9'd0) begin
      eff_cap = 9'd1;
    end
  end

  cle_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .eff_cap  (eff_cap),
    .q_full   (q_stat.full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  cle_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .stat    (q_stat)
  );

  cle_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_out),
    .q_empty (q_stat.empty),
    .cmd_pop (cmd_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  a_empty_after_reset: assert property (@(posedge clk) (!rst && $past(rst)) |-> empty)
    else $error("result pending after reset");

  a_abort_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.aborted) |-> (result.last && !result.echo_valid && !result.line_write))
    else $error("malformed abort result");

  a_write_printable: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.line_write) |->
      (result.line_char >= 7'h20 && result.line_char <= 7'h7e && result.line_index != 8'hff))
    else $error("stored character out of range");

  a_done_is_lf: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.line_done) |-> (result.echo_byte == CH_LF && result.last))
    else $error("line end not on LF result");

endmodule

// ===== src/cle_front.sv =====
// Front end of the console line editor: accepts requests, classifies each byte
// against the current line length and, unless it is ignored, pushes a command for the back end.
// Depends on cle_pkg.
module cle_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  cle_pkg::req_t request,
  input  logic [8:0]    eff_cap,
  input  logic          q_full,
  output logic          cmd_push,
  output cle_pkg::cmd_t cmd
);
  import cle_pkg::*;

  logic [7:0] cur_len;
  logic [7:0] cur_len_next;
  logic       cmd_valid;
  logic       accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    cmd_valid    = 1'b0;
    cmd.op       = OP_ABORT;
    cmd.len      = cur_len;
    cmd.chr      = request.rx_byte[6:0];
    cur_len_next = cur_len;
    if (request.req_type) begin
      cmd_valid    = 1'b1;
      cur_len_next = 8'd0;
    end else begin
      unique case (request.rx_byte) inside
        CH_CR, CH_LF: begin
          cmd_valid    = 1'b1;
          cmd.op       = OP_EOL;
          cur_len_next = 8'd0;
        end
        CH_BS, CH_DEL: begin
          if (cur_len != 8'd0) begin
            cmd_valid    = 1'b1;
            cmd.op       = OP_ERASE;
            cur_len_next = cur_len - 8'd1;
          end
        end
        default: begin
          if (request.rx_byte >= CH_SPACE && request.rx_byte <= CH_TILDE &&
              ({1'b0, cur_len} + 9'd1) < eff_cap) begin
            cmd_valid    = 1'b1;
            cmd.op       = OP_PUT;
            cur_len_next = cur_len + 8'd1;
          end
        end
      endcase
    end
  end

  assign cmd_push = accept && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_len <= 8'd0;
    end else if (accept) begin
      cur_len <= cur_len_next;
    end
  end

endmodule

// ===== src/cle_cmd_fifo.sv =====
// Short command queue between the front and back ends of the line editor.
// Register-based, one write and one read port, combinational head.
// Depends on cle_pkg.
module cle_cmd_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  cle_pkg::cmd_t      wr_data,
  input  logic               rd_en,
  output cle_pkg::cmd_t      rd_data,
  output cle_pkg::q_stat_t   stat
);
  import cle_pkg::*;

  cmd_t                 slots [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_PTR_W:0]   count;
  logic                 do_wr;
  logic                 do_rd;

  assign stat.full  = (count == (CMD_PTR_W+1)'(CMD_DEPTH));
  assign stat.empty = (count == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/cle_back.sv =====
// Back end of the line editor: expands each command into one to three results
// and holds them in the output register until popped.
// Depends on cle_pkg.
module cle_back (
  input  logic          clk,
  input  logic          rst,
  input  cle_pkg::cmd_t cmd,
  input  logic          q_empty,
  output logic          cmd_pop,
  output logic          empty,
  input  logic          pop,
  output cle_pkg::res_t result
);
  import cle_pkg::*;

  logic [1:0] step;
  logic       out_valid;
  logic       load;
  res_t       res_next;

  assign load  = !q_empty && (!out_valid || pop);
  assign empty = !out_valid;

  always_comb begin
    res_next = '0;
    unique case (cmd.op)
      OP_ABORT: begin
        res_next.aborted = 1'b1;
        res_next.last    = 1'b1;
      end
      OP_PUT: begin
        res_next.echo_valid = 1'b1;
        res_next.echo_byte  = {1'b0, cmd.chr};
        res_next.line_write = 1'b1;
        res_next.line_index = cmd.len;
        res_next.line_char  = cmd.chr;
        res_next.last       = 1'b1;
      end
      OP_EOL: begin
        res_next.echo_valid = 1'b1;
        if (step == 2'd0) begin
          res_next.echo_byte = CH_CR;
        end else begin
          res_next.echo_byte   = CH_LF;
          res_next.line_done   = 1'b1;
          res_next.line_length = cmd.len;
          res_next.last        = 1'b1;
        end
      end
      OP_ERASE: begin
        res_next.echo_valid = 1'b1;
        res_next.echo_byte  = (step == 2'd1) ? CH_SPACE : CH_BS;
        res_next.last       = (step == 2'd2);
      end
      default: begin
        res_next.last = 1'b1;
      end
    endcase
  end

  assign cmd_pop = load && res_next.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step <= res_next.last ? 2'd0 : step + 2'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res_next;
    end
  end

endmodule
